### hw/rtl/hcbs_pkg.sv
// Shared constants, register codes and lane interface types for the
// held-command boxcar smoother. No dependencies.
package hcbs_pkg;

  localparam int unsigned CMD_W      = 24;
  localparam int unsigned RATE_W     = 17;
  localparam int unsigned PERIOD_W   = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CMD_FIELDS = 6;
  localparam int unsigned CHANNELS   = 6;
  localparam int unsigned LANES      = CHANNELS + 1;
  localparam int unsigned WINDOW     = 200;

  localparam int unsigned PTR_W   = $clog2(WINDOW);
  localparam int unsigned SUM_W   = CMD_W + PTR_W;
  localparam int unsigned MAG_W   = SUM_W;
  localparam int unsigned DIV_K   = MAG_W + PTR_W;
  localparam int unsigned DIV_M_W = MAG_W + 1;

  // Reciprocal of WINDOW, exact for any dividend below 2**MAG_W
  localparam logic [63:0] DIV_M_L =
      ((64'd1 << DIV_K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_L[DIV_M_W-1:0];

  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_VALUE = CFG_IDX_W'(1);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET   = PERIOD_W'(5);
  localparam logic [CMD_W-1:0]    FALLBACK_RESET = CMD_W'(1);

  typedef struct packed {
    logic             acc;
    logic             adv;
    logic [PTR_W-1:0] addr;
    logic             zero;
  } lane_ctrl_t;

  typedef struct packed {
    logic             neg;
    logic [CMD_W-1:0] quot;
  } lane_res_t;

endpackage

### hw/rtl/hcbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hcbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/hcbs_lane.sv
// One filter lane: sample window in RAM, running sum and mean by reciprocal.
// Depends on hcbs_pkg and hcbs_ram.
module hcbs_lane (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hcbs_pkg::lane_ctrl_t             ctrl_i,
  input  logic signed [hcbs_pkg::CMD_W-1:0] sample_i,
  output hcbs_pkg::lane_res_t              res_o
);
  import hcbs_pkg::*;

  logic [CMD_W-1:0]               rdata;
  logic signed [CMD_W-1:0]        sample_q;
  logic signed [CMD_W-1:0]        old_val;
  logic [PTR_W-1:0]               addr_q;
  logic                           zero_q;
  logic signed [SUM_W-1:0]        sum_q;
  logic signed [SUM_W-1:0]        sum_d;
  logic [MAG_W-1:0]               mag;
  logic [MAG_W+DIV_M_W-1:0]       prod;
  lane_res_t                      res_q;

  hcbs_ram #(
    .WIDTH(CMD_W),
    .DEPTH(WINDOW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.adv),
    .waddr_i (addr_q),
    .wdata_i (sample_q),
    .re_i    (ctrl_i.acc),
    .raddr_i (ctrl_i.addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc) begin
      sample_q <= sample_i;
      addr_q   <= ctrl_i.addr;
      zero_q   <= ctrl_i.zero;
    end
  end

  // Entries not yet written since reset read as zero
  assign old_val = zero_q ? '0 : signed'(rdata);
  assign sum_d   = sum_q + SUM_W'(sample_q) - SUM_W'(old_val);
  assign mag     = sum_q[SUM_W-1] ? MAG_W'(-sum_q) : MAG_W'(sum_q);
  assign prod    = (MAG_W + DIV_M_W)'(mag) * (MAG_W + DIV_M_W)'(DIV_M);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.adv) begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      res_q.quot <= prod[DIV_K +: CMD_W];
      res_q.neg  <= sum_q[SUM_W-1];
    end
  end

  assign res_o = res_q;

endmodule

### hw/rtl/hcbs_merge.sv
// Merge stage: restores the sign of each lane mean and registers the result.
// Depends on hcbs_pkg.
module hcbs_merge (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              s2_valid_i,
  input  hcbs_pkg::lane_res_t [hcbs_pkg::LANES-1:0]         res_i,
  output logic                                              load_o,
  input  logic                                              out_stall_i,
  output logic                                              out_valid_o,
  output logic [hcbs_pkg::CMD_FIELDS-1:0][hcbs_pkg::CMD_W-1:0] vel_o,
  output logic [hcbs_pkg::RATE_W-1:0]                       rate_o
);
  import hcbs_pkg::*;

  logic                                out_valid_q;
  logic                                out_ready;
  logic [CMD_FIELDS-1:0][CMD_W-1:0]    vel_d;
  logic [CMD_FIELDS-1:0][CMD_W-1:0]    vel_q;
  logic [CMD_W-1:0]                    rate_full;
  logic [RATE_W-1:0]                   rate_q;

  function automatic logic [CMD_W-1:0] signed_mean(lane_res_t r);
    return r.neg ? CMD_W'(-r.quot) : r.quot;
  endfunction

  assign out_ready = !out_valid_q || !out_stall_i;
  assign load_o    = s2_valid_i && out_ready;

  always_comb begin
    vel_d = '0;
    for (int j = 0; j < CHANNELS; j++) begin
      vel_d[j] = signed_mean(res_i[j]);
    end
  end

  assign rate_full = signed_mean(res_i[CHANNELS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s2_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      vel_q  <= vel_d;
      rate_q <= rate_full[RATE_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign vel_o       = vel_q;
  assign rate_o      = rate_q;

endmodule

### hw/rtl/held_command_boxcar_smoother.sv
// Top level: held command latch, window pointer, lanes and merge stage.
// Depends on hcbs_pkg, hcbs_lane and hcbs_merge.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-------------------------------
//   in       | input     | in_valid_i / in_stall_o   | cmd_0_i..cmd_5_i, link_valid_i,
//            |           |                           | success_rate_i
//   out      | output    | out_valid_o / out_stall_i | vel_0_o..vel_5_o, rate_average_o
//   cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request per cycle while in_stall_o is low; a taken request passes the window
// RAM read, the running sum and reciprocal multiply, and the output register in turn.
// Each lane's window RAM takes one read and one write per request.
// Reset clears the sums and pointers; unwritten window entries read as zero
// until the pointer first wraps, so there is no clearing pass.
// An output stall fills the two internal stages and then raises in_stall_o.
module held_command_boxcar_smoother (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [hcbs_pkg::CMD_W-1:0]    cmd_0_i,
  input  logic signed [hcbs_pkg::CMD_W-1:0]    cmd_1_i,
  input  logic signed [hcbs_pkg::CMD_W-1:0]    cmd_2_i,
  input  logic signed [hcbs_pkg::CMD_W-1:0]    cmd_3_i,
  input  logic signed [hcbs_pkg::CMD_W-1:0]    cmd_4_i,
  input  logic signed [hcbs_pkg::CMD_W-1:0]    cmd_5_i,
  input  logic                                 link_valid_i,
  input  logic [hcbs_pkg::RATE_W-1:0]          success_rate_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [hcbs_pkg::CMD_W-1:0]    vel_0_o,
  output logic signed [hcbs_pkg::CMD_W-1:0]    vel_1_o,
  output logic signed [hcbs_pkg::CMD_W-1:0]    vel_2_o,
  output logic signed [hcbs_pkg::CMD_W-1:0]    vel_3_o,
  output logic signed [hcbs_pkg::CMD_W-1:0]    vel_4_o,
  output logic signed [hcbs_pkg::CMD_W-1:0]    vel_5_o,
  output logic [hcbs_pkg::RATE_W-1:0]          rate_average_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [hcbs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [hcbs_pkg::CMD_W-1:0]           cfg_data_i
);
  import hcbs_pkg::*;

  logic [PERIOD_W-1:0]                 period_q;
  logic [CMD_W-1:0]                    fallback_q;
  logic [PERIOD_W-1:0]                 period_eff;
  logic [PERIOD_W-1:0]                 phase_q;
  logic [PERIOD_W-1:0]                 phase_d;
  logic [PERIOD_W:0]                   phase_inc;
  logic [PTR_W-1:0]                    ptr_q;
  logic [PTR_W-1:0]                    ptr_d;
  logic                                ptr_last;
  logic                                wrapped_q;
  logic [CMD_FIELDS-1:0][CMD_W-1:0]    cmd_in;
  logic [CHANNELS-1:0][CMD_W-1:0]      held_q;
  logic [CHANNELS-1:0][CMD_W-1:0]      held_d;
  logic                                acc;
  logic                                adv1;
  logic                                load;
  logic                                s1_valid_q;
  logic                                s2_valid_q;
  lane_ctrl_t                          lane_ctrl;
  lane_res_t [LANES-1:0]               lane_res;
  logic [CMD_FIELDS-1:0][CMD_W-1:0]    vel;

  assign cmd_in[0] = cmd_0_i;
  assign cmd_in[1] = cmd_1_i;
  assign cmd_in[2] = cmd_2_i;
  assign cmd_in[3] = cmd_3_i;
  assign cmd_in[4] = cmd_4_i;
  assign cmd_in[5] = cmd_5_i;

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= PERIOD_RESET;
      fallback_q <= FALLBACK_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_REFRESH_PERIOD: period_q   <= cfg_data_i[PERIOD_W-1:0];
        REG_FALLBACK_VALUE: fallback_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control
  assign adv1       = s1_valid_q && (!s2_valid_q || load);
  assign in_stall_o = s1_valid_q && !adv1;
  assign acc        = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv1) begin
        s1_valid_q <= 1'b0;
      end
      if (adv1) begin
        s2_valid_q <= 1'b1;
      end else if (load) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // Tick phase and window pointer
  assign period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;
  assign phase_inc  = {1'b0, phase_q} + 1'b1;
  assign phase_d    = (phase_inc >= {1'b0, period_eff}) ? '0 : phase_inc[PERIOD_W-1:0];
  assign ptr_last   = (32'(ptr_q) == WINDOW - 1);
  assign ptr_d      = ptr_last ? '0 : ptr_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      ptr_q     <= '0;
      wrapped_q <= 1'b0;
      held_q    <= '0;
    end else if (acc) begin
      phase_q   <= phase_d;
      ptr_q     <= ptr_d;
      wrapped_q <= wrapped_q || ptr_last;
      held_q    <= held_d;
    end
  end

  always_comb begin
    held_d = held_q;
    if (phase_q == '0) begin
      for (int j = 0; j < CHANNELS; j++) begin
        held_d[j] = link_valid_i ? cmd_in[j] : fallback_q;
      end
    end
  end

  // Lanes
  assign lane_ctrl.acc  = acc;
  assign lane_ctrl.adv  = adv1;
  assign lane_ctrl.addr = ptr_q;
  assign lane_ctrl.zero = !wrapped_q;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_cmd_lane
    hcbs_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .sample_i (signed'(held_d[g])),
      .res_o    (lane_res[g])
    );
  end

  hcbs_lane u_rate_lane (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .sample_i (signed'({{(CMD_W - RATE_W){1'b0}}, success_rate_i})),
    .res_o    (lane_res[CHANNELS])
  );

  hcbs_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s2_valid_i  (s2_valid_q),
    .res_i       (lane_res),
    .load_o      (load),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .vel_o       (vel),
    .rate_o      (rate_average_o)
  );

  assign vel_0_o = signed'(vel[0]);
  assign vel_1_o = signed'(vel[1]);
  assign vel_2_o = signed'(vel[2]);
  assign vel_3_o = signed'(vel[3]);
  assign vel_4_o = signed'(vel[4]);
  assign vel_5_o = signed'(vel[5]);

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ptr_q) < WINDOW)
    else $error("window pointer out of range");

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> s1_valid_q)
    else $error("accepted request did not reach stage one");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with stage one empty");

  a_wrap_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrapped_q |=> wrapped_q)
    else $error("wrap flag cleared without reset");

  a_rate_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> !lane_res[CHANNELS].neg)
    else $error("rate lane sum went negative");
`endif

endmodule

### tb/held_command_boxcar_smoother_test.sv
// Self-checking bench for held_command_boxcar_smoother: random requests and stalls,
// register writes between phases, and a software copy of the smoother that predicts each result.
// Depends on hcbs_pkg and the held_command_boxcar_smoother top level.
module held_command_boxcar_smoother_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbs_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 600000;
  localparam int unsigned SETTLE_CYCLES = 8;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LOW  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HIGH = '1;

  localparam logic [CMD_W-1:0]  CMD_MAX  = {1'b0, {(CMD_W-1){1'b1}}};
  localparam logic [CMD_W-1:0]  CMD_MIN  = {1'b1, {(CMD_W-1){1'b0}}};
  localparam logic [CMD_W-1:0]  CMD_ONES = '1;
  localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(65536);
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  typedef struct packed {
    logic [CMD_FIELDS-1:0][CMD_W-1:0] cmd;
    logic                             link;
    logic [RATE_W-1:0]                rate;
  } tick_t;

  typedef struct packed {
    logic [CMD_FIELDS-1:0][CMD_W-1:0] vel;
    logic [RATE_W-1:0]                rate;
  } smoothed_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [CMD_W-1:0]  cmd_0_i = '0;
  logic signed [CMD_W-1:0]  cmd_1_i = '0;
  logic signed [CMD_W-1:0]  cmd_2_i = '0;
  logic signed [CMD_W-1:0]  cmd_3_i = '0;
  logic signed [CMD_W-1:0]  cmd_4_i = '0;
  logic signed [CMD_W-1:0]  cmd_5_i = '0;
  logic                     link_valid_i = 1'b0;
  logic [RATE_W-1:0]        success_rate_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [CMD_W-1:0]  vel_0_o;
  logic signed [CMD_W-1:0]  vel_1_o;
  logic signed [CMD_W-1:0]  vel_2_o;
  logic signed [CMD_W-1:0]  vel_3_o;
  logic signed [CMD_W-1:0]  vel_4_o;
  logic signed [CMD_W-1:0]  vel_5_o;
  logic [RATE_W-1:0]        rate_average_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [CMD_W-1:0]         cfg_data_i = '0;

  held_command_boxcar_smoother DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_0_i        (cmd_0_i),
    .cmd_1_i        (cmd_1_i),
    .cmd_2_i        (cmd_2_i),
    .cmd_3_i        (cmd_3_i),
    .cmd_4_i        (cmd_4_i),
    .cmd_5_i        (cmd_5_i),
    .link_valid_i   (link_valid_i),
    .success_rate_i (success_rate_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vel_0_o        (vel_0_o),
    .vel_1_o        (vel_1_o),
    .vel_2_o        (vel_2_o),
    .vel_3_o        (vel_3_o),
    .vel_4_o        (vel_4_o),
    .vel_5_o        (vel_5_o),
    .rate_average_o (rate_average_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Smoother copy: configuration, held commands, windows and running sums
  logic [PERIOD_W-1:0]     period_reg;
  logic signed [CMD_W-1:0] fallback_reg;
  logic signed [CMD_W-1:0] held_cmd [CHANNELS];
  logic signed [CMD_W-1:0] cmd_hist [CHANNELS][WINDOW];
  logic [RATE_W-1:0]       rate_hist [WINDOW];
  longint                  lane_sum [LANES];
  int unsigned             hist_ptr;
  int unsigned             tick_phase;

  tick_t       pending [$];
  smoothed_t   smoothed_due [$];
  int unsigned requests_queued = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned settings_applied = 0;
  int unsigned cycle_count = 0;
  logic        in_fire = 1'b0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned calm_left = 0;

  function automatic void reset_smoother();
    period_reg   = PERIOD_RESET;
    fallback_reg = FALLBACK_RESET;
    hist_ptr     = 0;
    tick_phase   = 0;
    for (int j = 0; j < CHANNELS; j++) begin
      held_cmd[j] = '0;
      for (int w = 0; w < WINDOW; w++) cmd_hist[j][w] = '0;
    end
    for (int w = 0; w < WINDOW; w++) rate_hist[w] = '0;
    for (int j = 0; j < LANES; j++) lane_sum[j] = 0;
  endfunction

  function automatic smoothed_t smooth_tick(input tick_t t);
    smoothed_t   r;
    longint      mean;
    int unsigned span;
    span = (period_reg == '0) ? 1 : int'(period_reg);
    r = '0;
    if (tick_phase == 0) begin
      for (int j = 0; j < CHANNELS; j++) held_cmd[j] = t.link ? t.cmd[j] : fallback_reg;
    end
    for (int j = 0; j < CHANNELS; j++) begin
      mean = lane_sum[j] / longint'(WINDOW);
      r.vel[j] = mean[CMD_W-1:0];
      lane_sum[j] += longint'(held_cmd[j]) - longint'(cmd_hist[j][hist_ptr]);
      cmd_hist[j][hist_ptr] = held_cmd[j];
    end
    mean = lane_sum[CHANNELS] / longint'(WINDOW);
    r.rate = mean[RATE_W-1:0];
    lane_sum[CHANNELS] += longint'(t.rate) - longint'(rate_hist[hist_ptr]);
    rate_hist[hist_ptr] = t.rate;
    hist_ptr   = (hist_ptr + 1 >= WINDOW) ? 0 : hist_ptr + 1;
    tick_phase = (tick_phase + 1 >= span) ? 0 : tick_phase + 1;
    return r;
  endfunction

  function automatic logic [CMD_W-1:0] random_cmd();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return CMD_MAX;
    if (r < 6) return CMD_MIN;
    if (r < 8) return '0;
    if (r < 10) return CMD_ONES;
    if (r < 40) return CMD_W'(int'($urandom_range(2000)) - 1000);
    return CMD_W'($urandom);
  endfunction

  function automatic logic [RATE_W-1:0] random_rate();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return RATE_ONE;
    if (r < 14) return RATE_MAX;
    if (r < 80) return RATE_W'($urandom_range(65536));
    return RATE_W'($urandom);
  endfunction

  function automatic tick_t random_tick(input int unsigned link_pct);
    tick_t t;
    for (int k = 0; k < CMD_FIELDS; k++) t.cmd[k] = random_cmd();
    t.link = ($urandom_range(99) < link_pct);
    t.rate = random_rate();
    return t;
  endfunction

  function automatic tick_t uniform_tick(input logic [CMD_W-1:0] v, input logic link,
                                         input logic [RATE_W-1:0] rate);
    tick_t t;
    for (int k = 0; k < CMD_FIELDS; k++) t.cmd[k] = v;
    t.link = link;
    t.rate = rate;
    return t;
  endfunction

  function automatic void queue_tick(input tick_t t);
    pending.push_back(t);
    requests_queued++;
  endfunction

  // Request driver
  always @(negedge clk_i) begin
    tick_t       t;
    int unsigned r;
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending.size() != 0) begin
        t = pending.pop_front();
        cmd_0_i        <= t.cmd[0];
        cmd_1_i        <= t.cmd[1];
        cmd_2_i        <= t.cmd[2];
        cmd_3_i        <= t.cmd[3];
        cmd_4_i        <= t.cmd[4];
        cmd_5_i        <= t.cmd[5];
        link_valid_i   <= t.link;
        success_rate_i <= t.rate;
        in_valid_i     <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
          gap_left = 0;
        end else begin
          r = $urandom_range(99);
          if (r < 3) burst_left = $urandom_range(20, 80);
          if (r < 50) gap_left = 0;
          else if (r < 85) gap_left = $urandom_range(1, 2);
          else if (r < 97) gap_left = $urandom_range(3, 6);
          else gap_left = $urandom_range(10, 40);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result stall generator
  always @(negedge clk_i) begin
    int unsigned r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left--;
      out_stall_i <= 1'b0;
    end else begin
      r = $urandom_range(99);
      if (r < 55) begin
        calm_left = $urandom_range(0, 8);
        out_stall_i <= 1'b0;
      end else if (r < 62) begin
        calm_left = $urandom_range(30, 120);
        out_stall_i <= 1'b0;
      end else if (r < 96) begin
        stall_left = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        stall_left = $urandom_range(10, 40);
        out_stall_i <= 1'b1;
      end
    end
  end

  // Register tracking, prediction and result checking
  always @(posedge clk_i) begin
    tick_t     t;
    smoothed_t got;
    smoothed_t want;
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_REFRESH_PERIOD) period_reg = cfg_data_i[PERIOD_W-1:0];
        else if (cfg_index_i == REG_FALLBACK_VALUE) fallback_reg = cfg_data_i;
      end
      if (in_valid_i && !in_stall_o) begin
        t.cmd[0] = cmd_0_i;
        t.cmd[1] = cmd_1_i;
        t.cmd[2] = cmd_2_i;
        t.cmd[3] = cmd_3_i;
        t.cmd[4] = cmd_4_i;
        t.cmd[5] = cmd_5_i;
        t.link   = link_valid_i;
        t.rate   = success_rate_i;
        smoothed_due.push_back(smooth_tick(t));
      end
      if (out_valid_o && !out_stall_i) begin
        got.vel[0] = vel_0_o;
        got.vel[1] = vel_1_o;
        got.vel[2] = vel_2_o;
        got.vel[3] = vel_3_o;
        got.vel[4] = vel_4_o;
        got.vel[5] = vel_5_o;
        got.rate   = rate_average_o;
        if (smoothed_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual rate_average %0d",
                   $time, got.rate);
        end else begin
          want = smoothed_due.pop_front();
          results_checked++;
          for (int k = 0; k < CMD_FIELDS; k++) begin
            if (got.vel[k] !== want.vel[k]) begin
              mismatches++;
              $display("%0t: vel_%0d expected %0d, actual %0d", $time, k,
                       $signed(want.vel[k]), $signed(got.vel[k]));
            end
          end
          if (got.rate !== want.rate) begin
            mismatches++;
            $display("%0t: rate_average expected %0d, actual %0d", $time,
                     want.rate, got.rate);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CMD_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    while (results_checked != requests_queued) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [PERIOD_W-1:0] period, input logic [CMD_W-1:0] fallback,
                           input int unsigned count, input int unsigned link_pct);
    write_reg(REG_REFRESH_PERIOD, {(CMD_W - PERIOD_W)'($urandom), period});
    write_reg(REG_FALLBACK_VALUE, fallback);
    settings_applied++;
    for (int i = 0; i < count; i++) queue_tick(random_tick(link_pct));
    settle();
  endtask

  initial begin
    tick_t t;
    reset_smoother();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: period 5, fallback latched on a missing link at tick 0
    queue_tick(uniform_tick('0, 1'b0, '0));
    queue_tick(uniform_tick(CMD_MAX, 1'b1, RATE_ONE));
    queue_tick(uniform_tick(CMD_MIN, 1'b1, RATE_MAX));
    queue_tick(uniform_tick(CMD_ONES, 1'b0, RATE_W'(1)));
    queue_tick(uniform_tick(CMD_W'(7), 1'b1, '0));
    queue_tick(uniform_tick(CMD_MAX, 1'b1, RATE_MAX));
    settle();
    settings_applied++;

    // Zero period latches every tick; unmapped indexes must not disturb anything
    write_reg(REG_REFRESH_PERIOD, '0);
    write_reg(REG_FALLBACK_VALUE, CMD_MIN);
    write_reg(REG_UNMAPPED_LOW, CMD_W'($urandom));
    write_reg(REG_UNMAPPED_HIGH, CMD_ONES);
    settings_applied++;
    queue_tick(uniform_tick(CMD_MAX, 1'b1, RATE_ONE));
    queue_tick(uniform_tick(CMD_MAX, 1'b1, RATE_MAX));
    queue_tick(uniform_tick(CMD_MIN, 1'b1, RATE_MAX));
    queue_tick(uniform_tick(CMD_MIN, 1'b1, '0));
    queue_tick(uniform_tick('0, 1'b1, RATE_ONE));
    queue_tick(uniform_tick(CMD_ONES, 1'b1, RATE_W'(1)));
    queue_tick(uniform_tick(CMD_MAX, 1'b0, RATE_MAX));
    queue_tick(uniform_tick(CMD_MAX, 1'b0, RATE_ONE));
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < CMD_FIELDS; k++) t.cmd[k] = ((k + i) % 2 != 0) ? CMD_MAX : CMD_MIN;
      t.link = 1'b1;
      t.rate = (i % 2 != 0) ? RATE_MAX : '0;
      queue_tick(t);
    end
    settle();

    run_phase(PERIOD_W'(1), CMD_MAX, 170, 50);
    run_phase('1, '0, 170, 80);
    run_phase(PERIOD_W'(3), CMD_W'($urandom), 170, 70);
    run_phase(PERIOD_W'($urandom_range(1, 255)), CMD_W'($urandom), 170, 80);
    run_phase(PERIOD_W'(2), CMD_ONES, 170, 60);
    run_phase(PERIOD_W'(5), CMD_W'($urandom), 170, 85);
    run_phase('0, CMD_MIN, 170, 75);
    run_phase(PERIOD_W'($urandom_range(2, 20)), CMD_W'($urandom), 170, 80);

    $display("covered %0d requests over %0d register settings, %0d results checked",
             requests_queued, settings_applied, results_checked);
    $display("mismatches: %0d, results still outstanding: %0d", mismatches,
             smoothed_due.size());
    if (mismatches == 0 && smoothed_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/hcbs_pkg.sv
hw/rtl/hcbs_ram.sv
hw/rtl/hcbs_lane.sv
hw/rtl/hcbs_merge.sv
hw/rtl/held_command_boxcar_smoother.sv
tb/held_command_boxcar_smoother_test.sv
